// ===== hw/rtl/pfs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfs_pkg
// Types and constants shared by the protobuf field scanner modules.
// ----------------------------------------------------------------------------
package pfs_pkg;

  typedef enum logic [1:0] {
    PH_TAG    = 2'd0,
    PH_VARINT = 2'd1,
    PH_SKIP   = 2'd2,
    PH_IDLE   = 2'd3
  } phase_t;

  localparam logic [1:0] ST_FOUND = 2'd0;
  localparam logic [1:0] ST_NONE  = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;

  localparam logic [2:0] WT_VARINT  = 3'd0;
  localparam logic [2:0] WT_FIXED64 = 3'd1;
  localparam logic [2:0] WT_LEN     = 3'd2;
  localparam logic [2:0] WT_FIXED32 = 3'd5;

  localparam logic [1:0] KIND_VARINT  = 2'd0;
  localparam logic [1:0] KIND_LEN     = 2'd1;
  localparam logic [1:0] KIND_FIXED32 = 2'd2;

  localparam logic CFG_WANTED_FIELD = 1'b0;
  localparam logic CFG_WANTED_KIND  = 1'b1;

  localparam logic [3:0] VARINT_LAST_GROUP = 4'd9;

  typedef struct packed {
    logic [28:0] wanted_field;
    logic [1:0]  wanted_kind;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] value;
    logic [15:0] offset;
  } res_t;

endpackage

// ===== hw/rtl/pfs_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfs_core
// Per-byte wire format decoder: tag and varint assembly, field skipping and
// match detection. State advances once for every transferred byte.
// ----------------------------------------------------------------------------
module pfs_core import pfs_pkg::*; #(
  parameter int MAX_MESSAGE_BYTES = 65536
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  cfg_t       cfg,
  output logic       res_valid,
  output res_t       res
);

  localparam int PW  = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam int SKW = $clog2(MAX_MESSAGE_BYTES + 2);
  localparam logic [PW-1:0]  POS_MAX    = PW'(MAX_MESSAGE_BYTES);
  localparam logic [SKW-1:0] SKIP_CLAMP = SKW'(MAX_MESSAGE_BYTES + 1);
  localparam logic [SKW-1:0] SKIP_FIX64 = SKW'(8);
  localparam logic [SKW-1:0] SKIP_FIX32 = SKW'(4);

  phase_t         phase_r, phase_nxt;
  logic [63:0]    acc_r, acc_nxt;
  logic [3:0]     gc_r, gc_nxt;
  logic [2:0]     wire_r, wire_nxt;
  logic           hit_r, hit_nxt;
  logic [SKW-1:0] skip_r, skip_nxt;
  logic [PW-1:0]  pos_r, pos_nxt;
  logic           ans_r, ans_nxt;

  logic [6:0]     vb_sh;
  logic [63:0]    vb_acc;
  logic           vb_done;
  logic           vb_long;
  logic [31:0]    tag_field;
  logic [2:0]     tag_wt;
  logic           same;
  logic [15:0]    pos16;
  logic [1:0]     fx_idx;
  logic [63:0]    acc_fx;
  logic [SKW-1:0] skip_dec;
  logic           give;

  always_comb begin
    vb_sh     = 7'(gc_r) * 7'd7;
    vb_acc    = acc_r | ({57'd0, data_byte[6:0]} << vb_sh);
    vb_done   = !data_byte[7];
    vb_long   = data_byte[7] && (gc_r == VARINT_LAST_GROUP);
    tag_field = vb_acc[34:3];
    tag_wt    = vb_acc[2:0];
    same      = (tag_field == {3'd0, cfg.wanted_field});
    pos16     = 16'(pos_r);
    fx_idx    = 2'(3'd4 - skip_r[2:0]);
    skip_dec  = skip_r - SKW'(1);
    acc_fx    = acc_r;
    if (wire_r == WT_FIXED32 && hit_r && skip_r >= SKW'(1) && skip_r <= SKIP_FIX32) begin
      acc_fx = acc_r | ({56'd0, data_byte} << {fx_idx, 3'b000});
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    gc_nxt    = gc_r;
    wire_nxt  = wire_r;
    hit_nxt   = hit_r;
    skip_nxt  = skip_r;
    ans_nxt   = ans_r;
    give      = 1'b0;
    res_valid = 1'b0;
    res       = '{status: ST_FOUND, value: 64'd0, offset: 16'd0};

    if (!ans_r && pos_r >= POS_MAX) begin
      give       = 1'b1;
      res.status = ST_BAD;
    end else begin
      unique case (phase_r)
        PH_TAG: begin
          gc_nxt = vb_done ? 4'd0 : gc_r + 4'd1;
          if (vb_long) begin
            give       = 1'b1;
            res.status = ST_BAD;
          end else if (vb_done) begin
            acc_nxt  = 64'd0;
            wire_nxt = tag_wt;
            if (tag_field == 32'd0) begin
              give       = 1'b1;
              res.status = ST_BAD;
            end else begin
              unique case (tag_wt)
                WT_VARINT: begin
                  phase_nxt = PH_VARINT;
                  hit_nxt   = same && cfg.wanted_kind == KIND_VARINT;
                end
                WT_LEN: begin
                  phase_nxt = PH_VARINT;
                  hit_nxt   = same && cfg.wanted_kind == KIND_LEN;
                end
                WT_FIXED64: begin
                  phase_nxt = PH_SKIP;
                  skip_nxt  = SKIP_FIX64;
                  hit_nxt   = 1'b0;
                end
                WT_FIXED32: begin
                  phase_nxt = PH_SKIP;
                  skip_nxt  = SKIP_FIX32;
                  hit_nxt   = same && cfg.wanted_kind == KIND_FIXED32;
                end
                default: begin
                  give       = 1'b1;
                  res.status = ST_BAD;
                end
              endcase
            end
          end else begin
            acc_nxt = vb_acc;
          end
        end

        PH_VARINT: begin
          gc_nxt = vb_done ? 4'd0 : gc_r + 4'd1;
          if (vb_long) begin
            give       = 1'b1;
            res.status = ST_BAD;
          end else if (vb_done) begin
            if (wire_r == WT_VARINT) begin
              if (hit_r) begin
                give      = 1'b1;
                res.value = vb_acc;
                acc_nxt   = vb_acc;
              end else begin
                phase_nxt = PH_TAG;
                acc_nxt   = 64'd0;
              end
            end else if (vb_acc == 64'd0) begin
              // Empty length-delimited payload: answer with the length byte.
              acc_nxt = 64'd0;
              if (hit_r) begin
                give       = 1'b1;
                res.offset = pos16 + 16'd1;
              end else begin
                phase_nxt = PH_TAG;
              end
            end else begin
              // Lengths past the message limit can never complete, so the
              // counter only needs to stay above the bytes that remain.
              skip_nxt  = (vb_acc > 64'(MAX_MESSAGE_BYTES)) ? SKIP_CLAMP
                                                            : vb_acc[SKW-1:0];
              phase_nxt = PH_SKIP;
              acc_nxt   = hit_r ? vb_acc : 64'd0;
            end
          end else begin
            acc_nxt = vb_acc;
          end
        end

        PH_SKIP: begin
          skip_nxt = skip_dec;
          acc_nxt  = acc_fx;
          if (skip_dec == '0) begin
            if (!hit_r) begin
              phase_nxt = PH_TAG;
              acc_nxt   = 64'd0;
            end else if (wire_r == WT_FIXED32) begin
              give      = 1'b1;
              res.value = acc_fx;
            end else begin
              give       = 1'b1;
              res.value  = acc_fx;
              res.offset = pos16 + 16'd1 - acc_fx[15:0];
            end
          end
        end

        PH_IDLE: begin
        end

        default: begin
        end
      endcase
    end

    if (give) begin
      res_valid = 1'b1;
      ans_nxt   = 1'b1;
      phase_nxt = PH_IDLE;
    end

    pos_nxt = (pos_r < POS_MAX) ? pos_r + PW'(1) : pos_r;

    if (last_byte) begin
      if (!ans_nxt) begin
        res_valid = 1'b1;
        res       = '{status: ((phase_nxt == PH_TAG && gc_nxt == 4'd0) ? ST_NONE : ST_BAD),
                      value: 64'd0, offset: 16'd0};
      end
      phase_nxt = PH_TAG;
      acc_nxt   = 64'd0;
      gc_nxt    = 4'd0;
      wire_nxt  = WT_VARINT;
      hit_nxt   = 1'b0;
      skip_nxt  = '0;
      pos_nxt   = '0;
      ans_nxt   = 1'b0;
    end

    res_valid = res_valid && step_en;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TAG;
      acc_r   <= 64'd0;
      gc_r    <= 4'd0;
      wire_r  <= WT_VARINT;
      hit_r   <= 1'b0;
      skip_r  <= '0;
      pos_r   <= '0;
      ans_r   <= 1'b0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      gc_r    <= gc_nxt;
      wire_r  <= wire_nxt;
      hit_r   <= hit_nxt;
      skip_r  <= skip_nxt;
      pos_r   <= pos_nxt;
      ans_r   <= ans_nxt;
    end
  end

  a_ans_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ans_r == (phase_r == PH_IDLE))
    else $error("answer flag and idle phase disagree");

  // An over-long varint leaves the index one past the tenth byte, but only
  // in the idle phase, where it is never read.
  a_group_bound: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_IDLE |-> gc_r <= VARINT_LAST_GROUP)
    else $error("varint group index past the tenth byte");

  a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_SKIP |-> skip_r != '0)
    else $error("skip phase with nothing left to skip");

  a_one_answer: assert property (@(posedge clk) disable iff (!rst_n)
    ans_r |-> !res_valid)
    else $error("result produced after the answer was given");

endmodule

// ===== hw/rtl/pfs_obuf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfs_obuf
// Two-entry result buffer: an output register with a skid register behind it,
// so the input side can keep moving while a result waits to be taken.
// ----------------------------------------------------------------------------
module pfs_obuf import pfs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t push_data,
  output logic full,
  output logic out_valid,
  input  logic out_stall,
  output res_t out_data
);

  logic out_v_r, out_v_nxt;
  res_t out_d_r, out_d_nxt;
  logic skid_v_r, skid_v_nxt;
  res_t skid_d_r, skid_d_nxt;
  logic out_free;

  always_comb begin
    out_free   = !out_v_r || !out_stall;
    out_v_nxt  = out_v_r;
    out_d_nxt  = out_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (out_free) begin
      if (skid_v_r) begin
        out_v_nxt  = 1'b1;
        out_d_nxt  = skid_d_r;
        skid_v_nxt = push;
        skid_d_nxt = push_data;
      end else begin
        out_v_nxt = push;
        out_d_nxt = push_data;
      end
    end else if (push) begin
      skid_v_nxt = 1'b1;
      skid_d_nxt = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign full      = skid_v_r;
  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid register holds a result while the output is empty");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !skid_v_r || out_free)
    else $error("result pushed into a full buffer");

  a_held_goes_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
    push && out_v_r && out_stall |=> skid_v_r)
    else $error("result pushed behind a stalled output was dropped");

endmodule

// ===== hw/rtl/protobuf_field_scanner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// protobuf_field_scanner
// Finds the first field with a configured number and kind in a protobuf
// message streamed one byte per transfer.
// ----------------------------------------------------------------------------
// One message byte is taken every clock cycle while in_stall is low. Each
// byte updates the decoder state, and its result (if any) goes to the output
// register, or the skid register while the output stalls. A result is
// produced when the wanted field completes, on a malformed byte, or on the
// byte marked last; afterwards bytes are absorbed silently until the last one.
// in_stall rises only when two results are queued behind a stalled output.
// Configure wanted_field (index 0) and wanted_kind (index 1) between messages.
module protobuf_field_scanner import pfs_pkg::*; #(
  parameter int MAX_MESSAGE_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [63:0] out_field_value,
  output logic [15:0] out_payload_offset,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [28:0] cfg_wr_data
);

  cfg_t cfg_r;
  logic step_en;
  logic res_valid;
  res_t res;
  res_t out_data;
  logic buf_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wanted_field <= 29'd1;
      cfg_r.wanted_kind  <= KIND_VARINT;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_WANTED_FIELD: cfg_r.wanted_field <= cfg_wr_data;
        CFG_WANTED_KIND:  cfg_r.wanted_kind  <= cfg_wr_data[1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_stall = buf_full;
  assign step_en  = in_valid && !buf_full;

  pfs_core #(
    .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res)
  );

  pfs_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_status         = out_data.status;
  assign out_field_value    = out_data.value;
  assign out_payload_offset = out_data.offset;

endmodule
